@@ hdl/rdi_pkg.sv @@
// Shared types, constants and helpers for the radial distortion inverse block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rdi_pkg;

  // Width of a Q4.28 radius and of a Q8.24 coefficient
  localparam int RAD_W = 32;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_R2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_R4 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_R6 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 2'd3;

  // Search limit after reset: 1.0 in Q4.28
  localparam logic [RAD_W-1:0] LIMIT_RESET = 32'h1000_0000;

  // 1.0 in Q.28, start of the distortion factor sum
  localparam logic [63:0] FACTOR_ONE = 64'h0000_0000_1000_0000;

  // Register stages of one forward evaluation
  localparam int FWD_LAT = 10;

  // One item in flight through the bisection chain
  typedef struct packed {
    logic             valid;
    logic             init;     // still waits for the limit check
    logic             capped;
    logic [RAD_W-1:0] rd;
    logic [RAD_W-1:0] lo;
    logic [RAD_W-1:0] hi;
  } item_t;

  // Coefficients held as sign and magnitude
  typedef struct packed {
    logic             neg1;
    logic             neg2;
    logic             neg3;
    logic [RAD_W-1:0] mag1;
    logic [RAD_W-1:0] mag2;
    logic [RAD_W-1:0] mag3;
  } coef_t;

  // Midpoint of an interval, floor((a + b) / 2) without overflow
  function automatic logic [RAD_W-1:0] mid_of(input logic [RAD_W-1:0] a,
                                              input logic [RAD_W-1:0] b);
    logic [RAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RAD_W:1];
  endfunction

endpackage

@@ hdl/rdi_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
// Depends on rdi_pkg for the radius width.
`timescale 1ns / 1ps

interface rdi_in_if;
  logic                    valid;
  logic                    ready;
  logic [rdi_pkg::RAD_W-1:0] distorted_radius;

  modport source (output valid, output distorted_radius, input ready);
  modport sink (input valid, input distorted_radius, output ready);
endinterface

interface rdi_out_if;
  logic                    valid;
  logic                    ready;
  logic [rdi_pkg::RAD_W-1:0] undistorted_radius;
  logic                    capped;

  modport source (output valid, output undistorted_radius, output capped, input ready);
  modport sink (input valid, input undistorted_radius, input capped, output ready);
endinterface

@@ hdl/rdi_fwd.sv @@
// Pipelined forward radial model f(r) = r * (1 + k1 r^2 + k2 r^4 + k3 r^6).
// Ten register stages, wide products split into partials. Depends on rdi_pkg.
`timescale 1ns / 1ps

module rdi_fwd (
  input  logic                      clk,
  input  logic                      en,
  input  rdi_pkg::coef_t            coef,
  input  logic [rdi_pkg::RAD_W-1:0] r_i,
  output logic [rdi_pkg::RAD_W-1:0] f_o
);

  localparam logic [63:0] FACTOR_ONE_S = rdi_pkg::FACTOR_ONE;

  // stage 1: r squared
  logic [31:0] r_1_r;
  logic [63:0] sq_1_r;

  // stage 2: partials of r2*r2 and k1*r2
  logic [31:0] r_2_r;
  logic [35:0] r2_2_r;
  logic [35:0] hh_2_r, hl_2_r, ll_2_r;
  logic [49:0] t1h_2_r, t1l_2_r;

  // stage 3: r4 and term 1
  logic [31:0] r_3_r;
  logic [35:0] r2_3_r;
  logic [43:0] r4_3_r;
  logic [43:0] t1_3_r;

  // stage 4: partials of r4*r2 and k2*r4
  logic [31:0] r_4_r;
  logic [43:0] t1_4_r;
  logic [39:0] ac_4_r, ad_4_r, bc_4_r, bd_4_r;
  logic [53:0] t2a_4_r, t2b_4_r;

  // stage 5: r6 and term 2
  logic [31:0] r_5_r;
  logic [43:0] t1_5_r;
  logic [51:0] r6_5_r;
  logic [51:0] t2_5_r;

  // stage 6: partials of k3*r6, sum of the first two terms
  logic [31:0] r_6_r;
  logic signed [63:0] s12_6_r;
  logic [57:0] t3u_6_r, t3v_6_r;

  // stage 7: term 3
  logic [31:0] r_7_r;
  logic signed [63:0] s12_7_r;
  logic [59:0] t3_7_r;

  // stage 8: factor, cleared when not positive
  logic [31:0] r_8_r;
  logic [59:0] fac_8_r;

  // stage 9: partials of r*factor
  logic [61:0] ph_9_r, pl_9_r;

  // stage 10: saturated result
  logic [31:0] f_10_r;

  // combinational helpers
  logic [71:0] s4;
  logic [67:0] st1;
  logic [79:0] s6;
  logic [75:0] st2;
  logic [83:0] st3;
  logic [91:0] sf;
  logic signed [63:0] term1, term2, term3, fac;

  always_comb begin
    s4  = {hh_2_r, 36'b0} + {17'b0, hl_2_r, 19'b0} + {36'b0, ll_2_r};
    st1 = {t1h_2_r, 18'b0} + {18'b0, t1l_2_r};
    s6  = {ac_4_r, 40'b0} + {18'b0, ad_4_r, 22'b0} + {22'b0, bc_4_r, 18'b0} + {40'b0, bd_4_r};
    st2 = {t2a_4_r, 22'b0} + {22'b0, t2b_4_r};
    st3 = {t3u_6_r, 26'b0} + {26'b0, t3v_6_r};
    sf  = {ph_9_r, 30'b0} + {30'b0, pl_9_r};
    // terms are truncated toward zero, so the sign goes on the magnitude
    term1 = $signed({20'b0, t1_5_r});
    if (coef.neg1) term1 = -term1;
    term2 = $signed({12'b0, t2_5_r});
    if (coef.neg2) term2 = -term2;
    term3 = $signed({4'b0, t3_7_r});
    if (coef.neg3) term3 = -term3;
    fac = s12_7_r + term3;
  end

  always_ff @(posedge clk) if (en) begin
    r_1_r  <= r_i;
    sq_1_r <= 64'(r_i) * 64'(r_i);

    r_2_r   <= r_1_r;
    r2_2_r  <= sq_1_r[63:28];
    hh_2_r  <= 36'(sq_1_r[63:46]) * 36'(sq_1_r[63:46]);
    hl_2_r  <= 36'(sq_1_r[63:46]) * 36'(sq_1_r[45:28]);
    ll_2_r  <= 36'(sq_1_r[45:28]) * 36'(sq_1_r[45:28]);
    t1h_2_r <= 50'(coef.mag1) * 50'(sq_1_r[63:46]);
    t1l_2_r <= 50'(coef.mag1) * 50'(sq_1_r[45:28]);

    r_3_r  <= r_2_r;
    r2_3_r <= r2_2_r;
    r4_3_r <= s4[71:28];
    t1_3_r <= st1[67:24];

    r_4_r   <= r_3_r;
    t1_4_r  <= t1_3_r;
    ac_4_r  <= 40'(r4_3_r[43:22]) * 40'(r2_3_r[35:18]);
    ad_4_r  <= 40'(r4_3_r[43:22]) * 40'(r2_3_r[17:0]);
    bc_4_r  <= 40'(r4_3_r[21:0]) * 40'(r2_3_r[35:18]);
    bd_4_r  <= 40'(r4_3_r[21:0]) * 40'(r2_3_r[17:0]);
    t2a_4_r <= 54'(coef.mag2) * 54'(r4_3_r[43:22]);
    t2b_4_r <= 54'(coef.mag2) * 54'(r4_3_r[21:0]);

    r_5_r  <= r_4_r;
    t1_5_r <= t1_4_r;
    r6_5_r <= s6[79:28];
    t2_5_r <= st2[75:24];

    r_6_r   <= r_5_r;
    s12_6_r <= $signed(FACTOR_ONE_S) + term1 + term2;
    t3u_6_r <= 58'(coef.mag3) * 58'(r6_5_r[51:26]);
    t3v_6_r <= 58'(coef.mag3) * 58'(r6_5_r[25:0]);

    r_7_r   <= r_6_r;
    s12_7_r <= s12_6_r;
    t3_7_r  <= st3[83:24];

    r_8_r   <= r_7_r;
    fac_8_r <= (!fac[63] && (fac != 64'sd0)) ? fac[59:0] : 60'd0;

    ph_9_r <= 62'(r_8_r) * 62'(fac_8_r[59:30]);
    pl_9_r <= 62'(r_8_r) * 62'(fac_8_r[29:0]);

    f_10_r <= (|sf[91:60]) ? 32'hFFFF_FFFF : sf[59:28];
  end

  assign f_o = f_10_r;

endmodule

@@ hdl/rdi_step.sv @@
// One bisection step: midpoint register, forward evaluation, interval update.
// Depends on rdi_pkg and rdi_fwd.
`timescale 1ns / 1ps

module rdi_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rdi_pkg::coef_t coef,
  input  rdi_pkg::item_t item_i,
  output rdi_pkg::item_t item_o
);

  localparam int LAT = rdi_pkg::FWD_LAT;

  rdi_pkg::item_t item0_r;
  logic [rdi_pkg::RAD_W-1:0] mid0_r;
  rdi_pkg::item_t dly_r [LAT];
  logic [rdi_pkg::RAD_W-1:0] mid_dly_r [LAT];
  rdi_pkg::item_t out_r, out_nxt;
  logic [rdi_pkg::RAD_W-1:0] f;

  // midpoint of the incoming interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item0_r.valid <= 1'b0;
    end else if (en) begin
      item0_r <= item_i;
    end
  end

  always_ff @(posedge clk) if (en) mid0_r <= rdi_pkg::mid_of(item_i.lo, item_i.hi);

  rdi_fwd u_fwd (
    .clk  (clk),
    .en   (en),
    .coef (coef),
    .r_i  (mid0_r),
    .f_o  (f)
  );

  // item travels beside the forward pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) dly_r[k].valid <= 1'b0;
    end else if (en) begin
      dly_r[0] <= item0_r;
      for (int k = 1; k < LAT; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  always_ff @(posedge clk) if (en) begin
    mid_dly_r[0] <= mid0_r;
    for (int k = 1; k < LAT; k++) mid_dly_r[k] <= mid_dly_r[k-1];
  end

  // interval update; the first step checks zero input and reach instead
  always_comb begin
    out_nxt = dly_r[LAT-1];
    if (dly_r[LAT-1].init) begin
      out_nxt.init = 1'b0;
      if (dly_r[LAT-1].rd == '0) begin
        out_nxt.lo = '0;
        out_nxt.hi = '0;
      end else if (f < dly_r[LAT-1].rd) begin
        out_nxt.lo     = dly_r[LAT-1].hi;
        out_nxt.capped = 1'b1;
      end else begin
        out_nxt.lo = '0;
      end
    end else if (f < dly_r[LAT-1].rd) begin
      out_nxt.lo = mid_dly_r[LAT-1];
    end else begin
      out_nxt.hi = mid_dly_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign item_o = out_r;

endmodule

@@ hdl/radial_distortion_inverse.sv @@
// Each step is a midpoint register, the ten-stage forward model pipeline and an update
// register; a final midpoint register follows the last step.
// Throughput: one transaction per cycle while the skid register is empty; the whole chain
// advances together, a skid register catches one result while the sink stalls, and the chain and input then stall.
// Reset: synchronous, active low; clears valid bits and loads register reset values.
`timescale 1ns / 1ps

module radial_distortion_inverse #(
  parameter int ITERATIONS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdi_pkg::RAD_W-1:0]     cfg_wdata,
  rdi_in_if.sink                        in_ch,
  rdi_out_if.source                     out_ch
);

  localparam int NSTEP = ITERATIONS + 1;

  rdi_pkg::coef_t coef_r;
  logic [rdi_pkg::RAD_W-1:0] limit_r;
  rdi_pkg::item_t chain [NSTEP+1];
  logic en;
  logic [rdi_pkg::RAD_W-1:0] mag_in;

  logic res_valid_r, res_capped_r;
  logic [rdi_pkg::RAD_W-1:0] res_rad_r;
  logic skid_valid_r, skid_capped_r;
  logic [rdi_pkg::RAD_W-1:0] skid_rad_r;

  // configuration registers, coefficients kept as sign and magnitude
  assign mag_in = cfg_wdata[31] ? (~cfg_wdata + 32'd1) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '0;
      limit_r <= rdi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdi_pkg::CFG_COEF_R2: begin
          coef_r.neg1 <= cfg_wdata[31];
          coef_r.mag1 <= mag_in;
        end
        rdi_pkg::CFG_COEF_R4: begin
          coef_r.neg2 <= cfg_wdata[31];
          coef_r.mag2 <= mag_in;
        end
        rdi_pkg::CFG_COEF_R6: begin
          coef_r.neg3 <= cfg_wdata[31];
          coef_r.mag3 <= mag_in;
        end
        rdi_pkg::CFG_SEARCH_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // chain advances unless the skid register holds a result
  assign en = !skid_valid_r;
  assign in_ch.ready = en;

  // first step evaluates the limit itself: lo = hi = limit
  always_comb begin
    chain[0].valid  = in_ch.valid;
    chain[0].init   = 1'b1;
    chain[0].capped = 1'b0;
    chain[0].rd     = in_ch.distorted_radius;
    chain[0].lo     = limit_r;
    chain[0].hi     = limit_r;
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    rdi_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .coef   (coef_r),
      .item_i (chain[s]),
      .item_o (chain[s+1])
    );
  end

  // final midpoint
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= chain[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) if (en) begin
    res_rad_r    <= rdi_pkg::mid_of(chain[NSTEP].lo, chain[NSTEP].hi);
    res_capped_r <= chain[NSTEP].capped;
  end

  // skid register for a stalled result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) skid_valid_r <= 1'b0;
    end else if (res_valid_r && !out_ch.ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) if (!skid_valid_r) begin
    skid_rad_r    <= res_rad_r;
    skid_capped_r <= res_capped_r;
  end

  assign out_ch.valid              = skid_valid_r | res_valid_r;
  assign out_ch.undistorted_radius = skid_valid_r ? skid_rad_r : res_rad_r;
  assign out_ch.capped             = skid_valid_r ? skid_capped_r : res_capped_r;

endmodule

@@ hdl/rdi_chk.sv @@
// Port-level checks for radial_distortion_inverse, bound to the top level.
// Depends on rdi_pkg and the channel interfaces of the top level.
`timescale 1ns / 1ps

module rdi_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rdi_pkg::RAD_W-1:0]     cfg_wdata,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rdi_pkg::RAD_W-1:0]     out_rad,
  input logic                          out_capped
);

  // shadow of the search limit
  logic [rdi_pkg::RAD_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= rdi_pkg::LIMIT_RESET;
    end else if (cfg_we && (cfg_index == rdi_pkg::CFG_SEARCH_LIMIT)) begin
      lim_r <= cfg_wdata;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rad) && $stable(out_capped))
    else $error("result changed while stalled");

  // a capped result is the search limit
  a_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_capped |-> out_rad == lim_r)
    else $error("capped result differs from limit");

  // a found radius lies inside the search interval
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_capped |-> out_rad <= lim_r)
    else $error("result beyond search limit");

  // input is only held off while a result is pending
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind radial_distortion_inverse rdi_chk u_rdi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_rad    (out_ch.undistorted_radius),
  .out_capped (out_ch.capped)
);

@@ tb/tb.sv @@
// Self-checking testbench for radial_distortion_inverse: fixed-point bisection inverse
// of the radial lens model, checked against an in-bench predictor. Needs rdi_pkg and rdi_if.
`timescale 1ns / 1ps

module tb;

  localparam int STEPS = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [rdi_pkg::RAD_W-1:0] radius;
    logic                      capped;
  } undist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rdi_pkg::RAD_W-1:0] cfg_wdata = '0;

  rdi_in_if in_ch ();
  rdi_out_if out_ch ();

  // Model copy of the lens registers
  logic [31:0] k1_reg, k2_reg, k3_reg, limit_reg;

  undist_t pending_radii[$];
  int mismatches = 0;
  int cycles = 0;
  bit sink_quiet = 1'b0;
  int sink_hold = 0;

  radial_distortion_inverse #(.ITERATIONS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(a*b / 2^sh), saturated to 64 bits
  function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  // k * x / 2^24, truncated toward zero
  function automatic longint lens_term(logic [31:0] k, logic [63:0] x);
    longint ks;
    logic [63:0] mag;
    longint p;
    ks = longint'($signed(k));
    mag = (ks < 0) ? -ks : ks;
    p = longint'(prod_shift(mag, x, 24));
    return (ks < 0) ? -p : p;
  endfunction

  // Distorted radius of r under the current coefficients
  function automatic logic [31:0] distort(logic [31:0] r);
    logic [63:0] r2, r4, r6, f;
    longint factor;
    r2 = ({32'b0, r} * {32'b0, r}) >> 28;
    r4 = prod_shift(r2, r2, 28);
    r6 = prod_shift(r4, r2, 28);
    factor = longint'(rdi_pkg::FACTOR_ONE) + lens_term(k1_reg, r2) + lens_term(k2_reg, r4)
             + lens_term(k3_reg, r6);
    if (factor <= 0) return '0;
    f = prod_shift({32'b0, r}, factor, 28);
    return (f > 64'hFFFF_FFFF) ? '1 : f[31:0];
  endfunction

  function automatic undist_t undistort(logic [31:0] rd);
    undist_t res;
    logic [32:0] lo, hi, mid;
    res.capped = 1'b0;
    res.radius = '0;
    if (rd == 0) return res;
    if (distort(limit_reg) < rd) begin
      res.radius = limit_reg;
      res.capped = 1'b1;
      return res;
    end
    lo = '0;
    hi = {1'b0, limit_reg};
    for (int i = 0; i < STEPS; i++) begin
      mid = (lo + hi) >> 1;
      if (distort(mid[31:0]) < rd) lo = mid;
      else hi = mid;
    end
    mid = (lo + hi) >> 1;
    res.radius = mid[31:0];
    return res;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink: random stalls, mostly short, with quiet stretches
  always @(negedge clk) begin
    if (cycles % 700 == 0) sink_quiet = $urandom_range(0, 2) == 0;
    if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!sink_quiet && $urandom_range(0, 7) == 0)
        sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  // Result checker
  always @(posedge clk) begin
    undist_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_radii.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: radius %h capped %b",
                                       out_ch.undistorted_radius, out_ch.capped);
      end else begin
        want = pending_radii.pop_front();
        if (out_ch.undistorted_radius !== want.radius || out_ch.capped !== want.capped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: radius exp %h got %h, capped exp %b got %b",
                     want.radius, out_ch.undistorted_radius, want.capped, out_ch.capped);
        end
      end
    end
  end

  // valid stays high after a transaction so that the next one can follow directly
  task automatic send_radius(logic [31:0] rd);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.distorted_radius <= rd;
    pending_radii.push_back(undistort(rd));
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_radii.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [rdi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rdi_pkg::CFG_COEF_R2: k1_reg = val;
      rdi_pkg::CFG_COEF_R4: k2_reg = val;
      rdi_pkg::CFG_COEF_R6: k3_reg = val;
      rdi_pkg::CFG_SEARCH_LIMIT: limit_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_lens(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] lim);
    write_reg(rdi_pkg::CFG_COEF_R2, a);
    write_reg(rdi_pkg::CFG_COEF_R4, b);
    write_reg(rdi_pkg::CFG_COEF_R6, c);
    write_reg(rdi_pkg::CFG_SEARCH_LIMIT, lim);
  endtask

  // Mostly radii within reach, the rest full range
  task automatic send_random(int n);
    logic [31:0] top;
    top = distort(limit_reg);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0 && top != 0) send_radius($urandom_range(1, top));
      else send_radius($urandom);
    end
  endtask

  // Reset values: identity lens over [0, 1.0]
  task automatic test_reset_defaults();
    send_radius('0);
    send_radius(32'h0000_0001);
    send_radius(32'h0800_0000);
    send_radius(32'h1000_0000);
    send_radius(32'h1000_0001);
    send_radius('1);
  endtask

  // Limits and coefficient extremes, zero and beyond-reach inputs
  task automatic test_extremes();
    set_lens(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_radius('0);
    send_radius('1);
    send_radius(32'h0000_0001);
    send_radius(32'h8000_0000);
    set_lens(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_radius('0);
    send_radius(32'h0000_0001);
    send_radius('1);
    // Non-monotonic: strong barrel term with a positive higher order
    set_lens(32'hFF80_0000, 32'h0040_0000, 32'h8000_0000, 32'h3000_0000);
    send_radius(32'h0400_0000);
    send_radius(32'h0FFF_FFFF);
    send_radius(32'h5555_5555);
    send_radius(32'hAAAA_AAAA);
  endtask

  // Realistic and wild coefficient sets, with one full drain in mid stream
  task automatic test_random_lenses();
    for (int p = 0; p < 4; p++) begin
      if (p == 3)
        set_lens($urandom, $urandom, $urandom, $urandom);
      else
        set_lens($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                 $urandom_range(0, 32'h0080_0000) - 32'h0040_0000,
                 $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                 $urandom_range(32'h0800_0000, 32'h2000_0000));
      send_random(200);
      if (p == 1) wait_drained();
      send_random(200);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.distorted_radius = '0;
    k1_reg = '0;
    k2_reg = '0;
    k3_reg = '0;
    limit_reg = rdi_pkg::LIMIT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_random_lenses();
    wait_drained();
    repeat (450) @(posedge clk);
    if (mismatches == 0 && pending_radii.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
